// ===== design/assert_macros.svh =====
// assertion macros shared by the lottery arbiter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LAB_ASSERT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define LAB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/lab_pkg.sv =====
// types and constants of the lottery arbiter with boost
package lab_pkg;

   localparam int NUM_SLOTS  = 64;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
   localparam int OUT_SLOT_W = 6;
   localparam int TICKET_W   = 16;
   localparam int BOOST_W    = 32;
   localparam int RND_W      = 31;
   localparam int EFF_W      = TICKET_W + 1;
   localparam int TOT_W      = EFF_W + SLOT_W;
   localparam int MCNT_W     = $clog2(RND_W + 1);

   localparam logic [RND_W-1:0] LCG_MUL = 31'd1103515245;
   localparam logic [RND_W-1:0] LCG_ADD = 31'd12345;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_BOOST = 2'd1,
      OP_DRAW  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_ZERO_TICKETS = 2'd1,
      ST_NO_WINNER    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_BOOST,
      S_SUM,
      S_MUL,
      S_ADD,
      S_MOD,
      S_SCAN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                runnable;
      logic [TICKET_W-1:0] ticket;
      logic [BOOST_W-1:0]  boost;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{runnable: 1'b0, ticket: TICKET_W'(1), boost: '0};

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      entry_type         wr_data;
   } tbl_req_type;

endpackage

// ===== design/lab_table.sv =====
// slot table memory with per-entry valid bits
module lab_table (
   input  logic                 clock,
   input  logic                 reset,
   input  lab_pkg::tbl_req_type tbl,
   output lab_pkg::entry_type   rd_entry
);
   import lab_pkg::*;

   entry_type          mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff;
   entry_type          rd_data_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (tbl.wr_en) begin
         mem[tbl.wr_addr] <= tbl.wr_data;
      end
      if (tbl.rd_en) begin
         rd_data_ff <= mem[tbl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (tbl.wr_en) begin
            valid_ff[tbl.wr_addr] <= 1'b1;
         end
         if (tbl.rd_en) begin
            rd_valid_ff <= valid_ff[tbl.rd_addr];
         end
      end
   end

   // never-written entries read as their reset contents
   assign rd_entry = rd_valid_ff ? rd_data_ff : ENTRY_RESET;

endmodule

// ===== design/lab_mod.sv =====
// restoring modulo unit, one dividend bit per cycle
module lab_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lab_pkg::RND_W-1:0]   dividend,
   input  logic [lab_pkg::TOT_W-1:0]   divisor,
   output logic                        done,
   output logic [lab_pkg::TOT_W-1:0]   remainder
);
   import lab_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MCNT_W-1:0] cnt_ff, cnt_in;
   logic [TOT_W-1:0]  rem_ff, rem_in;
   logic [TOT_W-1:0]  div_ff, div_in;
   logic [RND_W-1:0]  dvd_ff, dvd_in;
   logic [TOT_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      dvd_in  = dvd_ff;
      trial   = {rem_ff, dvd_ff[RND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = TOT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[TOT_W-1:0];
         end
         dvd_in = {dvd_ff[RND_W-2:0], 1'b0};
         cnt_in = cnt_ff + MCNT_W'(1);
         if (cnt_ff == MCNT_W'(RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      dvd_ff <= dvd_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

`include "assert_macros.svh"

   `LAB_ASSERT(a_rem_below_div, clock, reset, busy_ff, rem_ff < div_ff)
   `LAB_ASSERT_NEXT(a_done_single, clock, reset, done_ff, !done_ff)
   `LAB_ASSERT(a_no_restart, clock, reset, start, !busy_ff)

endmodule

// ===== design/lottery_arbiter_with_boost_top.sv =====
// top level of the lottery arbiter with wake-up boost
//
// req channel: one command per transfer (write slot, add boost, draw winner).
// rsp channel: exactly one result per command, in command order.
// csr_we/csr_wdata load the random seed into the generator state;
// write it only while no command is in flight.
// One command is worked on at a time. Slot writes and unused opcodes go
// from dispatch to the response state; a boost add reads the slot there and
// writes it back in the boost state. A draw reads the slot table through its
// single read port twice, once to sum the tickets and once to find the
// winner, and runs a 31-step modulo; an empty draw ends after the first
// pass.
// Reset clears all runnable flags and boosts, sets every ticket count to one
// and the generator state to zero; it takes effect at once, no clearing pass.
// A finished result sits in the output register until the receiver takes it;
// a following command is accepted meanwhile and waits with its own result
// until the output register frees up.
module lottery_arbiter_with_boost_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_opcode,
   input  logic [5:0]                     req_slot,
   input  logic                           req_runnable,
   input  logic [lab_pkg::TICKET_W-1:0]   req_ticket_count,
   input  logic [lab_pkg::BOOST_W-1:0]    req_boost_amount,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lab_pkg::OUT_SLOT_W-1:0] rsp_winner_slot,
   output logic                           rsp_winner_found,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_we,
   input  logic [lab_pkg::RND_W-1:0]      csr_wdata
);
   import lab_pkg::*;

   state_type             state_ff, state_in;
   op_type                op_ff;
   logic [5:0]            slot_ff;
   logic                  run_ff;
   logic [TICKET_W-1:0]   tick_ff;
   logic [BOOST_W-1:0]    boost_ff;

   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [SLOT_W-1:0]     ret_idx_ff, ret_idx_in;
   logic [TOT_W-1:0]      acc_ff, acc_in;
   logic [TOT_W-1:0]      run_sum_ff, run_sum_in;
   logic [RND_W-1:0]      mul_ff, mul_in;
   logic [RND_W-1:0]      random_state_ff, random_state_in;

   logic [OUT_SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic                  res_found_ff, res_found_in;
   status_type            res_status_ff, res_status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_SLOT_W-1:0] rsp_slot_ff;
   logic                  rsp_found_ff;
   status_type            rsp_status_ff;
   logic                  rsp_load;

   tbl_req_type           tbl;
   entry_type             rd;
   logic                  mod_start;
   logic [RND_W-1:0]      mod_dividend;
   logic                  mod_done;
   logic [TOT_W-1:0]      pick;

   logic                  slot_ok;
   logic [EFF_W-1:0]      eff;
   logic [TOT_W-1:0]      run_next;
   logic                  issue;
   logic                  pass_done;
   logic                  hit;
   logic [BOOST_W:0]      boost_sum;

   lab_table u_table (
      .clock    (clock),
      .reset    (reset),
      .tbl      (tbl),
      .rd_entry (rd)
   );

   lab_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (acc_ff),
      .done      (mod_done),
      .remainder (pick)
   );

   assign slot_ok   = 32'(slot_ff) < 32'(NUM_SLOTS);
   assign eff       = !rd.runnable ? '0 :
                      (rd.boost != '0) ? {rd.ticket, 1'b0} : {1'b0, rd.ticket};
   assign run_next  = run_sum_ff + TOT_W'(eff);
   assign issue     = idx_ff < CNT_W'(NUM_SLOTS);
   assign pass_done = (idx_ff == CNT_W'(NUM_SLOTS)) && !pend_ff;
   assign hit       = pend_ff && rd.runnable && (run_next > pick);
   assign boost_sum = {1'b0, rd.boost} + {1'b0, boost_ff};
   assign req_ready = (state_ff == S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (op_ff)
               OP_BOOST: state_in = slot_ok ? S_BOOST : S_RESP;
               OP_DRAW:  state_in = S_SUM;
               default:  state_in = S_RESP;
            endcase
         end
         S_BOOST: state_in = S_RESP;
         S_SUM: begin
            if (pass_done) state_in = (acc_ff == '0) ? S_RESP : S_MUL;
         end
         S_MUL: state_in = S_ADD;
         S_ADD: state_in = S_MOD;
         S_MOD: begin
            if (mod_done) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (hit || pass_done) state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      tbl             = '0;
      idx_in          = idx_ff;
      pend_in         = 1'b0;
      ret_idx_in      = ret_idx_ff;
      acc_in          = acc_ff;
      run_sum_in      = run_sum_ff;
      mul_in          = mul_ff;
      random_state_in = random_state_ff;
      res_slot_in     = res_slot_ff;
      res_found_in    = res_found_ff;
      res_status_in   = res_status_ff;
      mod_start       = 1'b0;
      mod_dividend    = mul_ff + LCG_ADD;
      rsp_load        = 1'b0;
      case (state_ff)
         S_DISPATCH: begin
            res_slot_in   = '0;
            res_found_in  = 1'b0;
            res_status_in = ST_OK;
            idx_in        = '0;
            acc_in        = '0;
            run_sum_in    = '0;
            case (op_ff)
               OP_WRITE: begin
                  if (tick_ff == '0) begin
                     res_status_in = ST_ZERO_TICKETS;
                  end else if (slot_ok) begin
                     tbl.wr_en            = 1'b1;
                     tbl.wr_addr          = SLOT_W'(slot_ff);
                     tbl.wr_data.runnable = run_ff;
                     tbl.wr_data.ticket   = tick_ff;
                     tbl.wr_data.boost    = boost_ff;
                  end
               end
               OP_BOOST: begin
                  if (slot_ok) begin
                     tbl.rd_en   = 1'b1;
                     tbl.rd_addr = SLOT_W'(slot_ff);
                  end
               end
               default: ;
            endcase
         end
         S_BOOST: begin
            tbl.wr_en         = 1'b1;
            tbl.wr_addr       = SLOT_W'(slot_ff);
            tbl.wr_data       = rd;
            tbl.wr_data.boost = boost_sum[BOOST_W] ? '1 : boost_sum[BOOST_W-1:0];
         end
         S_SUM: begin
            if (issue) begin
               tbl.rd_en   = 1'b1;
               tbl.rd_addr = idx_ff[SLOT_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
               pend_in     = 1'b1;
            end
            if (pend_ff) begin
               acc_in = acc_ff + TOT_W'(eff);
            end
            if (pass_done) begin
               idx_in = '0;
               if (acc_ff == '0) res_status_in = ST_NO_WINNER;
            end
         end
         S_MUL: begin
            mul_in = random_state_ff * LCG_MUL;
         end
         S_ADD: begin
            random_state_in = mod_dividend;
            mod_start       = 1'b1;
         end
         S_SCAN: begin
            if (issue && !hit) begin
               tbl.rd_en   = 1'b1;
               tbl.rd_addr = idx_ff[SLOT_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
               pend_in     = 1'b1;
               ret_idx_in  = idx_ff[SLOT_W-1:0];
            end
            if (pend_ff) begin
               run_sum_in = run_next;
            end
            if (hit) begin
               res_slot_in  = OUT_SLOT_W'(ret_idx_ff);
               res_found_in = 1'b1;
               if (rd.boost != '0) begin
                  tbl.wr_en         = 1'b1;
                  tbl.wr_addr       = ret_idx_ff;
                  tbl.wr_data       = rd;
                  tbl.wr_data.boost = rd.boost - BOOST_W'(1);
               end
            end else if (pass_done) begin
               res_status_in = ST_NO_WINNER;
            end
         end
         S_RESP: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
      if (state_ff == S_SUM && issue) begin
         ret_idx_in = idx_ff[SLOT_W-1:0];
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         idx_ff          <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         random_state_ff <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            random_state_ff <= csr_wdata;
         end else begin
            random_state_ff <= random_state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff    <= op_type'(req_opcode);
         slot_ff  <= req_slot;
         run_ff   <= req_runnable;
         tick_ff  <= req_ticket_count;
         boost_ff <= req_boost_amount;
      end
      ret_idx_ff    <= ret_idx_in;
      acc_ff        <= acc_in;
      run_sum_ff    <= run_sum_in;
      mul_ff        <= mul_in;
      res_slot_ff   <= res_slot_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_winner_slot  = rsp_slot_ff;
   assign rsp_winner_found = rsp_found_ff;
   assign rsp_status       = rsp_status_ff;

`include "assert_macros.svh"

   `LAB_ASSERT(a_wr_states, clock, reset, tbl.wr_en, (state_ff == S_DISPATCH || state_ff == S_BOOST || state_ff == S_SCAN))
   `LAB_ASSERT(a_mod_done_waiting, clock, reset, mod_done, state_ff == S_MOD)
   `LAB_ASSERT(a_rnd_hold, clock, reset, (!$past(reset) && !$past(csr_we) && $past(state_ff) != S_ADD), $stable(random_state_ff))

endmodule
